### hw/rtl/nbcs_pkg.sv
// ============================================================================
// nbcs_pkg - shared types and constants of the naive Bayes class scorer
// Field widths, score limits and the record that travels along the cell chain.
// ============================================================================
package nbcs_pkg;

    localparam int CLS_W     = 4;
    localparam int WORD_W    = 12;
    localparam int PARAM_W   = 24;
    localparam int SCORE_W   = 48;
    localparam int CFG_W     = 5;
    localparam int WORD_SPAN = 2 ** WORD_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    // transaction modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_TOKEN = 1'b1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // One transaction slot as it moves from cell to cell, with the running argmax.
    typedef struct packed {
        logic                      vld;
        logic                      ld;
        logic                      add;
        logic                      res;
        logic [CLS_W-1:0]          cls;
        logic [WORD_W-1:0]         word;
        logic signed [PARAM_W-1:0] val;
        logic [CLS_W-1:0]          best_cls;
        logic signed [SCORE_W-1:0] best_score;
    } chain_t;

endpackage

### hw/rtl/naive_bayes_class_scorer_core.sv
// ============================================================================
// naive_bayes_class_scorer_core - multinomial naive Bayes scorer with argmax
// A chain of class cells, each with its own table bank and 48-bit score.
// ============================================================================
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  s_      | in        | s_valid / s_ready | mode, class, word, param, flags
//  m_      | out       | m_valid / m_ready | best_class, best_score
//  cfg_    | in        | cfg_we            | active_classes (5 bits)
//
//  One transaction enters per cycle while the chain is not stalled; each cell
//  registers its bank read, then its score update and argmax, and a result
//  passes through every cell before it is loaded into the output register.
//  Reset clears scores, pipeline valids and the output valid; the table banks are
//  not cleared and hold nothing meaningful until loaded.
//  The chain stalls only when a result reaches its tail while the previous
//  result still waits in the output register.
module naive_bayes_class_scorer_core #(
    parameter int CLASS_CNT  = 16,
    parameter int VOCAB_SIZE = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [nbcs_pkg::CFG_W-1:0]          cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [nbcs_pkg::CLS_W-1:0]          s_class_index,
    input  logic [nbcs_pkg::WORD_W-1:0]         s_word_index,
    input  logic signed [nbcs_pkg::PARAM_W-1:0] s_param_value,
    input  logic                                s_token_valid,
    input  logic                                s_last_token,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nbcs_pkg::CLS_W-1:0]          m_best_class,
    output logic signed [nbcs_pkg::SCORE_W-1:0] m_best_score
);

    // words beyond the port's reach never touch a bank
    localparam int MEM_DEPTH = (VOCAB_SIZE < nbcs_pkg::WORD_SPAN) ? VOCAB_SIZE
                                                                  : nbcs_pkg::WORD_SPAN;
    localparam int CNT_W = $clog2(CLASS_CNT + 1);
    localparam int CMP_W = (CNT_W > nbcs_pkg::CFG_W) ? CNT_W : nbcs_pkg::CFG_W;

    logic [nbcs_pkg::CFG_W-1:0]          active_reg;
    logic [CMP_W-1:0]                    active_ext;
    logic [CMP_W-1:0]                    n_cmp;
    logic [CNT_W-1:0]                    n_eff;

    nbcs_pkg::chain_t                    link [CLASS_CNT+1];
    nbcs_pkg::chain_t                    tail;
    logic                                tail_res;
    logic                                adv;
    logic                                word_ok;

    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [nbcs_pkg::CLS_W-1:0]          m_cls_reg;
    logic signed [nbcs_pkg::SCORE_W-1:0] m_score_reg;

    // configuration: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= nbcs_pkg::ACTIVE_RESET;
        end else if (cfg_we) begin
            active_reg <= cfg_wdata;
        end
    end

    // clamp the active count to one..CLASS_CNT
    always_comb begin
        active_ext = CMP_W'(active_reg);
        if (active_ext == '0) begin
            n_cmp = CMP_W'(1);
        end else if (active_ext > CMP_W'(CLASS_CNT)) begin
            n_cmp = CMP_W'(CLASS_CNT);
        end else begin
            n_cmp = active_ext;
        end
        n_eff = CNT_W'(n_cmp);
    end

    // advance the chain unless a second result would land on a waiting one
    assign tail     = link[CLASS_CNT];
    assign tail_res = tail.vld && tail.res;
    assign adv      = !(tail_res && m_valid_reg && !m_ready);
    assign s_ready  = adv;

    // decode the incoming transaction once; a bubble when nothing is taken
    assign word_ok = 32'(s_word_index) < 32'(VOCAB_SIZE);

    always_comb begin
        link[0].vld        = s_valid && s_ready;
        link[0].ld         = (s_mode == nbcs_pkg::MODE_LOAD) && word_ok
                             && (32'(s_class_index) < 32'(CLASS_CNT));
        link[0].add        = (s_mode == nbcs_pkg::MODE_TOKEN) && s_token_valid && word_ok;
        link[0].res        = (s_mode == nbcs_pkg::MODE_TOKEN) && s_last_token;
        link[0].cls        = s_class_index;
        link[0].word       = s_word_index;
        link[0].val        = s_param_value;
        link[0].best_cls   = '0;
        link[0].best_score = '0;
    end

    for (genvar c = 0; c < CLASS_CNT; c++) begin : g_cell
        nbcs_cell #(
            .CELL_IDX  (c),
            .MEM_DEPTH (MEM_DEPTH),
            .CNT_W     (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .n_eff     (n_eff),
            .chain_in  (link[c]),
            .chain_out (link[c+1])
        );
    end

    // output register: hold the result until taken, load the next from the tail
    assign m_valid_next = (m_valid_reg && !m_ready) || (adv && tail_res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_res) begin
            m_cls_reg   <= tail.best_cls;
            m_score_reg <= tail.best_score;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_class = m_cls_reg;
    assign m_best_score = m_score_reg;

`ifndef SYNTHESIS
    a_reset_drops_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg && tail_res)
        else $error("input stalled without a waiting result");

    a_best_class_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (CLASS_CNT > 16)
                        || ((CNT_W+4)'(m_cls_reg) < (CNT_W+4)'(n_eff)))
        else $error("best class outside the active range");
`endif

endmodule

### hw/rtl/nbcs_cell.sv
// ============================================================================
// nbcs_cell - one class cell of the scorer chain
// Holds one class's table bank and score; updates the score and the argmax.
// ============================================================================
module nbcs_cell #(
    parameter int CELL_IDX  = 0,
    parameter int MEM_DEPTH = 4096,
    parameter int CNT_W     = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic [CNT_W-1:0]     n_eff,
    input  nbcs_pkg::chain_t     chain_in,
    output nbcs_pkg::chain_t     chain_out
);

    localparam int   AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic FIRST   = (CELL_IDX == 0);
    localparam logic HAS_CLS = (CELL_IDX < 2 ** nbcs_pkg::CLS_W);

    logic signed [nbcs_pkg::PARAM_W-1:0] mem [MEM_DEPTH];
    logic signed [nbcs_pkg::PARAM_W-1:0] rd_data_reg;

    nbcs_pkg::chain_t                    a_reg;
    nbcs_pkg::chain_t                    out_reg;
    nbcs_pkg::chain_t                    out_next;
    logic signed [nbcs_pkg::SCORE_W-1:0] score_reg;
    logic signed [nbcs_pkg::SCORE_W-1:0] score_next;

    logic                                wr_hit;
    logic [AW-1:0]                       addr;
    logic                                active;
    logic signed [nbcs_pkg::SCORE_W:0]   sum;
    logic signed [nbcs_pkg::SCORE_W-1:0] upd;
    logic                                take;

    assign addr   = chain_in.word[AW-1:0];
    assign wr_hit = HAS_CLS && chain_in.vld && chain_in.ld
                    && (chain_in.cls == nbcs_pkg::CLS_W'(CELL_IDX));
    assign active = CNT_W'(CELL_IDX) < n_eff;

    // table bank: write on a load hit, registered read for the passing token
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (wr_hit) begin
                mem[addr] <= chain_in.val;
            end
            rd_data_reg <= mem[addr];
        end
    end

    always_comb begin
        sum = {score_reg[nbcs_pkg::SCORE_W-1], score_reg}
            + {{(nbcs_pkg::SCORE_W+1-nbcs_pkg::PARAM_W){rd_data_reg[nbcs_pkg::PARAM_W-1]}},
               rd_data_reg};
        if (a_reg.vld && a_reg.add && active) begin
            if (sum[nbcs_pkg::SCORE_W] != sum[nbcs_pkg::SCORE_W-1]) begin
                upd = sum[nbcs_pkg::SCORE_W] ? nbcs_pkg::SCORE_MIN : nbcs_pkg::SCORE_MAX;
            end else begin
                upd = sum[nbcs_pkg::SCORE_W-1:0];
            end
        end else begin
            upd = score_reg;
        end
        take = a_reg.vld && a_reg.res && active && (FIRST || (upd > a_reg.best_score));
        out_next = a_reg;
        if (take) begin
            out_next.best_cls   = nbcs_pkg::CLS_W'(CELL_IDX);
            out_next.best_score = upd;
        end
        score_next = (a_reg.vld && a_reg.res) ? '0 : upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.vld   <= 1'b0;
            out_reg.vld <= 1'b0;
            score_reg   <= '0;
        end else if (adv) begin
            a_reg     <= chain_in;
            out_reg   <= out_next;
            score_reg <= score_next;
        end
    end

    assign chain_out = out_reg;

endmodule

### test/tb_naive_bayes_class_scorer_core.sv
// ============================================================================
// tb_naive_bayes_class_scorer_core - self-checking bench for the class scorer
// Loads a pool of table words, runs directed documents (ties, extremes, invalid
// and mid-document tokens, load-with-last), sweeps the active class count and
// then streams random documents under several idle patterns and a long output
// hold-off. A scoring predictor runs alongside and checks every verdict.
// ============================================================================
module tb_naive_bayes_class_scorer_core;

    localparam int NCLS          = 16;
    localparam int NWORDS        = 4096;
    localparam int CHAIN_LATENCY = 2 * NCLS;       // accept edge to output register
    localparam int HOLD_CYCLES   = 500;            // long receiver hold-off
    localparam int STALL_LIMIT   = 4000;           // cycles without any transaction

    localparam logic signed [nbcs_pkg::PARAM_W-1:0] PARAM_MAX =
        {1'b0, {(nbcs_pkg::PARAM_W-1){1'b1}}};
    localparam logic signed [nbcs_pkg::PARAM_W-1:0] PARAM_MIN =
        {1'b1, {(nbcs_pkg::PARAM_W-1){1'b0}}};

    typedef struct {
        logic                                mode;
        logic [nbcs_pkg::CLS_W-1:0]          cls;
        logic [nbcs_pkg::WORD_W-1:0]         word;
        logic signed [nbcs_pkg::PARAM_W-1:0] val;
        logic                                tvalid;
        logic                                last;
    } nb_item_t;

    typedef struct {
        logic [nbcs_pkg::CLS_W-1:0]          cls;
        logic signed [nbcs_pkg::SCORE_W-1:0] score;
    } verdict_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_we;
    logic [nbcs_pkg::CFG_W-1:0]          cfg_wdata;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_mode;
    logic [nbcs_pkg::CLS_W-1:0]          s_class_index;
    logic [nbcs_pkg::WORD_W-1:0]         s_word_index;
    logic signed [nbcs_pkg::PARAM_W-1:0] s_param_value;
    logic                                s_token_valid;
    logic                                s_last_token;
    logic                                m_valid;
    logic                                m_ready;
    logic [nbcs_pkg::CLS_W-1:0]          m_best_class;
    logic signed [nbcs_pkg::SCORE_W-1:0] m_best_score;

    // Predictor state: table image, running scores and the class-count register
    logic signed [nbcs_pkg::PARAM_W-1:0] param_image [0:NCLS*NWORDS-1];
    logic signed [nbcs_pkg::SCORE_W-1:0] class_score [NCLS];
    logic [nbcs_pkg::CFG_W-1:0]          active_cfg;
    verdict_t                            pending_verdicts [$];
    logic [nbcs_pkg::WORD_W-1:0]         pool_words [$];      // words loaded for every class

    int src_idle_pct;
    int sink_idle_pct;
    int hold_tickets;
    int mismatches;
    int items_sent;
    int docs_scored;
    int cfg_writes;

    naive_bayes_class_scorer_core #(
        .CLASS_CNT  (NCLS),
        .VOCAB_SIZE (NWORDS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_class_index (s_class_index),
        .s_word_index  (s_word_index),
        .s_param_value (s_param_value),
        .s_token_valid (s_token_valid),
        .s_last_token  (s_last_token),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_class  (m_best_class),
        .m_best_score  (m_best_score)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Scoring predictor
    // ------------------------------------------------------------------------

    // Add one table entry to a score, clamping to the 48-bit signed range
    function automatic logic signed [nbcs_pkg::SCORE_W-1:0] sat_add48(
        logic signed [nbcs_pkg::SCORE_W-1:0] acc, logic signed [nbcs_pkg::PARAM_W-1:0] inc);
        longint sum;
        sum = longint'(acc) + longint'(inc);
        if (sum > longint'(nbcs_pkg::SCORE_MAX)) begin
            return nbcs_pkg::SCORE_MAX;
        end
        if (sum < longint'(nbcs_pkg::SCORE_MIN)) begin
            return nbcs_pkg::SCORE_MIN;
        end
        return sum[nbcs_pkg::SCORE_W-1:0];
    endfunction

    // Apply one accepted transaction; queue a verdict when a document closes
    task automatic update_scores(input nb_item_t it);
        int       n_cls;
        verdict_t v;
        n_cls = (active_cfg == 0) ? 1 : ((active_cfg > NCLS) ? NCLS : int'(active_cfg));
        if (it.mode == nbcs_pkg::MODE_LOAD) begin
            // a last mark on a load means nothing
            param_image[{it.cls, it.word}] = it.val;
            return;
        end
        if (it.tvalid) begin
            for (int c = 0; c < n_cls; c++) begin
                class_score[c] = sat_add48(class_score[c],
                                           param_image[{nbcs_pkg::CLS_W'(c), it.word}]);
            end
        end
        if (it.last) begin
            // lowest index wins a tie, so only a strictly greater score moves on
            v.cls   = '0;
            v.score = class_score[0];
            for (int c = 1; c < n_cls; c++) begin
                if (class_score[c] > v.score) begin
                    v.score = class_score[c];
                    v.cls   = nbcs_pkg::CLS_W'(c);
                end
            end
            pending_verdicts.push_back(v);
            docs_scored++;
            for (int c = 0; c < NCLS; c++) begin
                class_score[c] = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------

    function automatic logic signed [nbcs_pkg::PARAM_W-1:0] random_param();
        case ($urandom_range(9))
            0: begin
                return PARAM_MAX;
            end
            1: begin
                return PARAM_MIN;
            end
            default: begin
                return nbcs_pkg::PARAM_W'($urandom);
            end
        endcase
    endfunction

    function automatic logic [nbcs_pkg::WORD_W-1:0] pool_word();
        return pool_words[$urandom_range(pool_words.size() - 1)];
    endfunction

    function automatic nb_item_t load_item(logic [nbcs_pkg::CLS_W-1:0] cls,
                                           logic [nbcs_pkg::WORD_W-1:0] word,
                                           logic signed [nbcs_pkg::PARAM_W-1:0] val,
                                           logic last);
        nb_item_t it;
        it.mode   = nbcs_pkg::MODE_LOAD;
        it.cls    = cls;
        it.word   = word;
        it.val    = val;
        it.tvalid = 1'($urandom);
        it.last   = last;
        return it;
    endfunction

    function automatic nb_item_t token_item(logic [nbcs_pkg::WORD_W-1:0] word, logic tvalid,
                                            logic last);
        nb_item_t it;
        it.mode   = nbcs_pkg::MODE_TOKEN;
        it.cls    = nbcs_pkg::CLS_W'($urandom);
        it.word   = word;
        it.val    = nbcs_pkg::PARAM_W'($urandom);
        it.tvalid = tvalid;
        it.last   = last;
        return it;
    endfunction

    // Mostly well-formed documents over loaded words, with loads and
    // invalid tokens on random words mixed in as noise
    function automatic nb_item_t random_item(int last_pct);
        int                          pick;
        logic [nbcs_pkg::WORD_W-1:0] w;
        pick = $urandom_range(99);
        if (pick < 18) begin
            w = (pick < 9) ? pool_word() : nbcs_pkg::WORD_W'($urandom);
            return load_item(nbcs_pkg::CLS_W'($urandom), w, random_param(), 1'($urandom));
        end
        if ($urandom_range(99) < 88) begin
            return token_item(pool_word(), 1'b1, $urandom_range(99) < last_pct);
        end
        return token_item(nbcs_pkg::WORD_W'($urandom), 1'b0, $urandom_range(99) < last_pct);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one transaction, idling first at the current rate, and hold it until taken
    task automatic send_item(input nb_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_mode        <= it.mode;
        s_class_index <= it.cls;
        s_word_index  <= it.word;
        s_param_value <= it.val;
        s_token_valid <= it.tvalid;
        s_last_token  <= it.last;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        update_scores(it);
        items_sent++;
    endtask

    // Drop valid, wait for every verdict, then let the chain empty out
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (CHAIN_LATENCY + 8) @(posedge aclk);
    endtask

    task automatic set_active(input int value);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= nbcs_pkg::CFG_W'(value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        active_cfg = nbcs_pkg::CFG_W'(value);
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------------

    // Drive m_ready at the current idle rate; a new ticket starts a long hold-off
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_tickets != hold_seen) begin
                hold_seen = hold_tickets;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // Compare each result transaction with the oldest verdict waiting
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result, class", -1, longint'(m_best_class));
            end else begin
                v = pending_verdicts.pop_front();
                if (m_best_class !== v.cls) begin
                    report_mismatch("best_class", longint'(v.cls), longint'(m_best_class));
                end
                if (m_best_score !== v.score) begin
                    report_mismatch("best_score", longint'(v.score), longint'(m_best_score));
                end
            end
        end
    end

    // End the run if no transaction moves for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (aresetn === 1'b1);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_naive_bayes_class_scorer_core NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Load every class for a pool of words; valid tokens only ever use these
    task automatic test_preload();
        pool_words.push_back('0);
        pool_words.push_back('1);
        repeat (14) pool_words.push_back(nbcs_pkg::WORD_W'($urandom_range(1, NWORDS / 2 - 1)));
        foreach (pool_words[i]) begin
            for (int c = 0; c < NCLS; c++) begin
                send_item(load_item(nbcs_pkg::CLS_W'(c), pool_words[i], random_param(),
                                    1'($urandom)));
            end
        end
    endtask

    task automatic test_special_cases();
        logic [nbcs_pkg::WORD_W-1:0] tie_w;
        logic [nbcs_pkg::WORD_W-1:0] fwd_w;
        logic [nbcs_pkg::WORD_W-1:0] blank_w;
        tie_w   = pool_words[2];
        fwd_w   = pool_words[3];
        blank_w = nbcs_pkg::WORD_W'($urandom_range(NWORDS / 2, NWORDS - 2));
        // invalid last token on a never-loaded word: adds nothing, still gives a verdict
        send_item(token_item(blank_w, 1'b0, 1'b1));
        // two classes tie at the largest entry; the second load carries a last mark
        send_item(load_item(nbcs_pkg::CLS_W'(3), tie_w, PARAM_MAX, 1'b0));
        send_item(load_item(nbcs_pkg::CLS_W'(9), tie_w, PARAM_MAX, 1'b1));
        send_item(token_item(tie_w, 1'b1, 1'b1));
        // extreme entries at both ends of the vocabulary and the class range
        send_item(load_item(nbcs_pkg::CLS_W'(NCLS - 1), '1, PARAM_MAX, 1'b0));
        send_item(load_item('0, '0, PARAM_MIN, 1'b0));
        send_item(load_item(nbcs_pkg::CLS_W'(NCLS - 1), '0, PARAM_MIN, 1'b0));
        send_item(token_item('1, 1'b1, 1'b0));
        send_item(token_item('0, 1'b1, 1'b0));
        send_item(token_item('0, 1'b1, 1'b1));
        // an invalid token in mid document adds nothing
        send_item(token_item(tie_w, 1'b1, 1'b0));
        send_item(token_item(tie_w, 1'b0, 1'b0));
        send_item(token_item('1, 1'b1, 1'b1));
        // a load followed at once by a token for the same word
        send_item(load_item(nbcs_pkg::CLS_W'(5), fwd_w, PARAM_MAX, 1'b0));
        send_item(token_item(fwd_w, 1'b1, 1'b1));
    endtask

    // Sweep the class count, out-of-range settings included
    task automatic test_class_counts();
        int counts [7];
        counts = '{0, 1, 31, 17, 2, 15, 16};
        foreach (counts[i]) begin
            set_active(counts[i]);
            send_item(token_item(pool_word(), 1'b1, 1'b0));
            send_item(token_item(pool_word(), 1'b1, 1'b1));
        end
    endtask

    // Random documents; pause halfway until every verdict is back
    task automatic test_random(input int count, input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                wait_idle();
            end
            send_item(random_item(20));
        end
        // close the open document so that a setting can change afterwards
        send_item(token_item(pool_word(), 1'b1, 1'b1));
    endtask

    // Hold the output off while short documents keep coming, so the chain backs up
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_tickets++;
        repeat (150) send_item(random_item(60));
        send_item(token_item(pool_word(), 1'b1, 1'b1));
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_mode        = nbcs_pkg::MODE_LOAD;
        s_class_index = '0;
        s_word_index  = '0;
        s_param_value = '0;
        s_token_valid = 1'b0;
        s_last_token  = 1'b0;
        active_cfg    = nbcs_pkg::ACTIVE_RESET;
        src_idle_pct  = 16;
        sink_idle_pct = 75;
        hold_tickets  = 0;
        mismatches    = 0;
        items_sent    = 0;
        docs_scored   = 0;
        cfg_writes    = 0;
        for (int c = 0; c < NCLS; c++) begin
            class_score[c] = '0;
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_preload();
        test_special_cases();
        test_class_counts();

        set_active(NCLS);
        test_random(400, 16, 75);
        set_active($urandom_range(2, NCLS - 1));
        test_random(400, 75, 16);
        set_active(31);
        test_random(250, 0, 0);
        set_active(1);
        test_random(150, 0, 0);
        set_active($urandom_range(0, 31));
        test_backpressure();

        wait_idle();
        if (pending_verdicts.size() != 0) begin
            report_mismatch("verdicts left over", 0, pending_verdicts.size());
        end
        $display("run: %0d transactions in, %0d documents scored, %0d class-count writes,",
                 items_sent, docs_scored, cfg_writes);
        $display("     idle patterns on both sides, a drain pause and a long output hold-off");
        if (mismatches == 0) begin
            $display("tb_naive_bayes_class_scorer_core OK");
        end else begin
            $display("tb_naive_bayes_class_scorer_core NOT OK");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/nbcs_pkg.sv
hw/rtl/nbcs_cell.sv
hw/rtl/naive_bayes_class_scorer_core.sv
test/tb_naive_bayes_class_scorer_core.sv
